@@ design/bsm_pkg.sv @@
// ---------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants for the battery state monitor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsm_pkg;

  localparam int unsigned VOLT_W  = 13;
  localparam int unsigned CUR_W   = 12;
  localparam int unsigned TEMP_W  = 12;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned LOW_W   = 6;
  localparam int unsigned CRIT_W  = 5;
  localparam int unsigned LIMIT_W = 11;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CIDX_W  = 2;

  localparam logic [VOLT_W-1:0] V_MIN_MV = 13'd3000;
  localparam logic [VOLT_W-1:0] V_MAX_MV = 13'd4200;

  // reciprocal of three, exact for quotients below 512
  localparam logic [7:0] RECIP3   = 8'd171;
  localparam int unsigned RECIP_SH = 9;

  localparam logic signed [CUR_W-1:0] CUR_FAST    = -12'sd500;
  localparam logic signed [CUR_W-1:0] CUR_SLOW    = -12'sd100;
  localparam logic signed [CUR_W-1:0] CUR_TRICKLE = -12'sd10;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0] PCT_HIGH = 7'd80;

  localparam logic [LOW_W-1:0]   LOW_RST  = 6'd20;
  localparam logic [CRIT_W-1:0]  CRIT_RST = 5'd10;
  localparam logic [LIMIT_W-1:0] TCRIT_RST = 11'd550;
  localparam logic [LIMIT_W-1:0] TREL_RST  = 11'd450;

  typedef enum logic [CIDX_W-1:0] {
    REG_LOW   = 2'd0,
    REG_CRIT  = 2'd1,
    REG_TCRIT = 2'd2,
    REG_TREL  = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    CHG_NONE     = 3'd0,
    CHG_FAST     = 3'd1,
    CHG_SLOW     = 3'd2,
    CHG_TRICKLE  = 3'd3,
    CHG_COMPLETE = 3'd4,
    CHG_ERROR    = 3'd5
  } charge_code_t;

  typedef enum logic [2:0] {
    BAT_NORMAL   = 3'd0,
    BAT_HIGH     = 3'd1,
    BAT_FULL     = 3'd2,
    BAT_LOW      = 3'd3,
    BAT_CRITICAL = 3'd4,
    BAT_CHARGING = 3'd5
  } battery_code_t;

  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_DISABLE = 2'd1,
    CMD_ENABLE  = 2'd2
  } charge_cmd_t;

  typedef enum logic [1:0] {
    TEV_NONE   = 2'd0,
    TEV_HIGH   = 2'd1,
    TEV_NORMAL = 2'd2
  } temp_event_t;

  typedef enum logic [2:0] {
    SEV_NONE     = 3'd0,
    SEV_LOW      = 3'd1,
    SEV_CRITICAL = 3'd2,
    SEV_NORMAL   = 3'd3,
    SEV_CHARGING = 3'd4
  } state_event_t;

  typedef struct packed {
    logic [LOW_W-1:0]   low_threshold;
    logic [CRIT_W-1:0]  critical_threshold;
    logic [LIMIT_W-1:0] temp_critical_limit;
    logic [LIMIT_W-1:0] temp_release_limit;
  } cfg_t;

  typedef struct packed {
    logic [PCT_W-1:0] percent;
    charge_code_t     charge_code;
    battery_code_t    battery_code;
    charge_cmd_t      charge_command;
    temp_event_t      temp_event;
    state_event_t     state_event;
    logic             temp_warning;
  } result_t;

endpackage

`default_nettype wire

@@ design/battery_state_monitor.sv @@
// ---------------------------------------------------------------------------
// battery_state_monitor
// Per-measurement battery supervisor: charge percentage, charge class,
// temperature hysteresis and battery mode events.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one measurement item per valid/ready handshake
//   out_* : one result item per input item, same order, valid/ready
//   cfg_* : write-only register port, cfg_we with cfg_index and cfg_wdata;
//           write only while no item is in flight
// Order: an accepted item is held in the input register, evaluated and
//   captured in the result register, which presents its result.
// Throughput: one item per cycle while out_ready is high, set by the single
//   evaluation pass between the input register and the result register.
// Reset: thresholds return to 20 / 10 percent and 550 / 450 tenths of a
//   degree, battery mode to normal and the temperature warning to clear.
// Stall: while out_ready is low the result holds; the input register still
//   takes one more item, then in_ready drops until the result is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module battery_state_monitor (
  input  wire logic                                clk,
  input  wire logic                                rst_n,

  input  wire logic                                cfg_we,
  input  wire logic [bsm_pkg::CIDX_W-1:0]          cfg_index,
  input  wire logic [bsm_pkg::CFG_W-1:0]           cfg_wdata,

  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [bsm_pkg::VOLT_W-1:0]          in_voltage_mv,
  input  wire logic signed [bsm_pkg::CUR_W-1:0]    in_current_ma,
  input  wire logic signed [bsm_pkg::TEMP_W-1:0]   in_temp_decidegree,
  input  wire logic                                in_charge_enabled,

  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [bsm_pkg::PCT_W-1:0]                out_percent,
  output logic [2:0]                               out_charge_code,
  output logic [2:0]                               out_battery_code,
  output logic [1:0]                               out_charge_command,
  output logic [1:0]                               out_temp_event,
  output logic [2:0]                               out_state_event,
  output logic                                     out_temp_warning
);
  import bsm_pkg::*;

  cfg_t cfg_r;

  logic                      s1_valid_r;
  logic [VOLT_W-1:0]         s1_volt_r;
  logic signed [CUR_W-1:0]   s1_cur_r;
  logic signed [TEMP_W-1:0]  s1_temp_r;
  logic                      s1_chg_r;

  logic                      out_valid_r;
  result_t                   out_r;

  battery_code_t             mode_r;
  logic                      warn_r;

  logic                      out_adv;
  logic                      s1_adv;
  logic [PCT_W-1:0]          pct;
  result_t                   res;

  assign out_adv  = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_adv;
  assign in_ready = !s1_valid_r || out_adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_threshold       <= LOW_RST;
      cfg_r.critical_threshold  <= CRIT_RST;
      cfg_r.temp_critical_limit <= TCRIT_RST;
      cfg_r.temp_release_limit  <= TREL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOW:   cfg_r.low_threshold       <= cfg_wdata[LOW_W-1:0];
        REG_CRIT:  cfg_r.critical_threshold  <= cfg_wdata[CRIT_W-1:0];
        REG_TCRIT: cfg_r.temp_critical_limit <= cfg_wdata[LIMIT_W-1:0];
        REG_TREL:  cfg_r.temp_release_limit  <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_volt_r <= in_voltage_mv;
      s1_cur_r  <= in_current_ma;
      s1_temp_r <= in_temp_decidegree;
      s1_chg_r  <= in_charge_enabled;
    end
  end

  bsm_pct_map u_pct (
    .voltage_mv (s1_volt_r),
    .percent    (pct)
  );

  bsm_eval u_eval (
    .percent         (pct),
    .current_ma      (s1_cur_r),
    .temp_decidegree (s1_temp_r),
    .charge_enabled  (s1_chg_r),
    .cfg             (cfg_r),
    .battery_mode    (mode_r),
    .warning_flag    (warn_r),
    .res             (res)
  );

  // monitor state, advanced once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= BAT_NORMAL;
      warn_r <= 1'b0;
    end else if (s1_adv) begin
      mode_r <= res.battery_code;
      warn_r <= res.temp_warning;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_percent        = out_r.percent;
  assign out_charge_code    = out_r.charge_code;
  assign out_battery_code   = out_r.battery_code;
  assign out_charge_command = out_r.charge_command;
  assign out_temp_event     = out_r.temp_event;
  assign out_state_event    = out_r.state_event;
  assign out_temp_warning   = out_r.temp_warning;

  a_warn_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (warn_r == out_r.temp_warning))
    else $error("warning state differs from last result");

  a_mode_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (mode_r == out_r.battery_code))
    else $error("battery mode differs from last result");

  a_temp_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.temp_event == TEV_HIGH) |-> out_r.temp_warning)
    else $error("temperature high event without warning");

  a_charging_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.battery_code == BAT_CHARGING)
      |-> (out_r.charge_code != CHG_NONE))
    else $error("charging mode without charge class");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.percent <= PCT_FULL))
    else $error("percentage out of range");

endmodule

`default_nettype wire

@@ design/bsm_pct_map.sv @@
// ---------------------------------------------------------------------------
// bsm_pct_map
// Clamped linear map of battery voltage to charge percentage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsm_pct_map (
  input  wire logic [bsm_pkg::VOLT_W-1:0] voltage_mv,
  output logic      [bsm_pkg::PCT_W-1:0]  percent
);
  import bsm_pkg::*;

  logic [VOLT_W-1:0] diff;
  logic [8:0]        quarter;
  logic [16:0]       prod;

  // (mv - 3000) / 12 = ((mv - 3000) >> 2) / 3
  assign diff    = voltage_mv - V_MIN_MV;
  assign quarter = diff[10:2];
  assign prod    = 17'(quarter) * 17'(RECIP3);

  always_comb begin
    if (voltage_mv <= V_MIN_MV) begin
      percent = '0;
    end else if (voltage_mv >= V_MAX_MV) begin
      percent = PCT_FULL;
    end else begin
      percent = prod[RECIP_SH +: PCT_W];
    end
  end

endmodule

`default_nettype wire

@@ design/bsm_eval.sv @@
// ---------------------------------------------------------------------------
// bsm_eval
// Charge class, temperature hysteresis and battery mode with event decode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsm_eval (
  input  wire logic [bsm_pkg::PCT_W-1:0]         percent,
  input  wire logic signed [bsm_pkg::CUR_W-1:0]  current_ma,
  input  wire logic signed [bsm_pkg::TEMP_W-1:0] temp_decidegree,
  input  wire logic                              charge_enabled,
  input  wire bsm_pkg::cfg_t                     cfg,
  input  wire bsm_pkg::battery_code_t            battery_mode,
  input  wire logic                              warning_flag,
  output bsm_pkg::result_t                       res
);
  import bsm_pkg::*;

  logic signed [TEMP_W:0] temp_ext;
  logic signed [TEMP_W:0] crit_ext;
  logic signed [TEMP_W:0] rel_ext;
  logic [PCT_W-1:0]       low_ext;
  logic [PCT_W-1:0]       crit_pct_ext;

  assign temp_ext     = {temp_decidegree[TEMP_W-1], temp_decidegree};
  assign crit_ext     = $signed({2'b00, cfg.temp_critical_limit});
  assign rel_ext      = $signed({2'b00, cfg.temp_release_limit});
  assign low_ext      = PCT_W'(cfg.low_threshold);
  assign crit_pct_ext = PCT_W'(cfg.critical_threshold);

  always_comb begin
    res         = '0;
    res.percent = percent;

    if (!charge_enabled) begin
      res.charge_code = CHG_NONE;
    end else if (current_ma < CUR_FAST) begin
      res.charge_code = CHG_FAST;
    end else if (current_ma < CUR_SLOW) begin
      res.charge_code = CHG_SLOW;
    end else if (current_ma < CUR_TRICKLE) begin
      res.charge_code = CHG_TRICKLE;
    end else if (percent >= PCT_FULL) begin
      res.charge_code = CHG_COMPLETE;
    end else begin
      res.charge_code = CHG_ERROR;
    end

    res.charge_command = CMD_NONE;
    res.temp_event     = TEV_NONE;
    res.temp_warning   = warning_flag;
    if (temp_ext > crit_ext) begin
      res.charge_command = CMD_DISABLE;
      res.temp_warning   = 1'b1;
      if (!warning_flag) begin
        res.temp_event = TEV_HIGH;
      end
    end else if (temp_ext < rel_ext && warning_flag) begin
      res.charge_command = CMD_ENABLE;
      res.temp_event     = TEV_NORMAL;
      res.temp_warning   = 1'b0;
    end

    if (charge_enabled) begin
      res.battery_code = BAT_CHARGING;
    end else if (percent <= crit_pct_ext) begin
      res.battery_code = BAT_CRITICAL;
    end else if (percent <= low_ext) begin
      res.battery_code = BAT_LOW;
    end else if (percent >= PCT_FULL) begin
      res.battery_code = BAT_FULL;
    end else if (percent > PCT_HIGH) begin
      res.battery_code = BAT_HIGH;
    end else begin
      res.battery_code = BAT_NORMAL;
    end

    res.state_event = SEV_NONE;
    if (res.battery_code != battery_mode) begin
      case (res.battery_code)
        BAT_LOW:      res.state_event = SEV_LOW;
        BAT_CRITICAL: res.state_event = SEV_CRITICAL;
        BAT_CHARGING: res.state_event = SEV_CHARGING;
        default:      res.state_event = SEV_NORMAL;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the battery state monitor. A short table of
// measurements covers field extremes, every charge class and the threshold
// edges. Random measurements then run under several register settings.
// Each result is checked against the table or a cycle-free model of the monitor. Both
// handshake sides idle in random bursts except under two of the settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import bsm_pkg::*;

  typedef struct packed {
    logic [VOLT_W-1:0]        mv;
    logic signed [CUR_W-1:0]  cur;
    logic signed [TEMP_W-1:0] temp;
    logic                     chg;
  } meas_t;

  typedef struct {
    int      mv;
    int      cur;
    int      temp;
    bit      chg;
    bit      known;
    result_t want;
  } probe_t;

  localparam int N_PROBES       = 23;
  localparam int ITEMS_PER_SET  = 200;
  localparam int N_SETS         = 6;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CIDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic [VOLT_W-1:0]        in_voltage_mv;
  logic signed [CUR_W-1:0]  in_current_ma;
  logic signed [TEMP_W-1:0] in_temp_decidegree;
  logic                     in_charge_enabled;
  logic                     out_valid;
  logic                     out_ready;
  logic [PCT_W-1:0]         out_percent;
  logic [2:0]               out_charge_code;
  logic [2:0]               out_battery_code;
  logic [1:0]               out_charge_command;
  logic [1:0]               out_temp_event;
  logic [2:0]               out_state_event;
  logic                     out_temp_warning;

  battery_state_monitor i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_voltage_mv      (in_voltage_mv),
    .in_current_ma      (in_current_ma),
    .in_temp_decidegree (in_temp_decidegree),
    .in_charge_enabled  (in_charge_enabled),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_percent        (out_percent),
    .out_charge_code    (out_charge_code),
    .out_battery_code   (out_battery_code),
    .out_charge_command (out_charge_command),
    .out_temp_event     (out_temp_event),
    .out_state_event    (out_state_event),
    .out_temp_warning   (out_temp_warning)
  );

  // monitor copy: registers and state
  logic [LOW_W-1:0]   thr_low;
  logic [CRIT_W-1:0]  thr_crit;
  logic [LIMIT_W-1:0] lim_hot;
  logic [LIMIT_W-1:0] lim_cool;
  battery_code_t      mode_now;
  logic               hot_flag;

  result_t pending_results [$];
  result_t head_result;

  int      idle_level;
  int      stall_left;
  int      n_errors;
  int      n_items;
  int      n_results;
  int      n_state_events;
  int      n_temp_events;
  int      n_settings;
  int      prev_mv;
  bit      chg_level;

  probe_t  probe_rows [N_PROBES] = '{
    '{0,    0,     250,   1'b0, 1'b1,
      '{7'd0, CHG_NONE, BAT_CRITICAL, CMD_NONE, TEV_NONE, SEV_CRITICAL, 1'b0}},
    '{5000, 0,     250,   1'b0, 1'b1,
      '{7'd100, CHG_NONE, BAT_FULL, CMD_NONE, TEV_NONE, SEV_NORMAL, 1'b0}},
    '{8191, 2047,  2047,  1'b0, 1'b1,
      '{7'd100, CHG_NONE, BAT_FULL, CMD_DISABLE, TEV_HIGH, SEV_NONE, 1'b1}},
    '{4200, -2048, -2048, 1'b1, 1'b1,
      '{7'd100, CHG_FAST, BAT_CHARGING, CMD_ENABLE, TEV_NORMAL, SEV_CHARGING, 1'b0}},
    '{3000, -501,  550,   1'b1, 1'b0, '0},
    '{3001, -500,  551,   1'b1, 1'b0, '0},
    '{4199, -101,  551,   1'b1, 1'b0, '0},
    '{3500, -100,  450,   1'b1, 1'b0, '0},
    '{3500, -11,   449,   1'b1, 1'b0, '0},
    '{4200, -10,   250,   1'b1, 1'b0, '0},
    '{4199, -10,   250,   1'b1, 1'b1,
      '{7'd99, CHG_ERROR, BAT_CHARGING, CMD_NONE, TEV_NONE, SEV_NONE, 1'b0}},
    '{4199, 2047,  250,   1'b1, 1'b0, '0},
    '{4199, 0,     250,   1'b0, 1'b0, '0},
    '{3972, 0,     250,   1'b0, 1'b0, '0},
    '{3971, 0,     250,   1'b0, 1'b0, '0},
    '{3240, 0,     250,   1'b0, 1'b0, '0},
    '{3252, 0,     250,   1'b0, 1'b0, '0},
    '{3120, 0,     250,   1'b0, 1'b0, '0},
    '{3132, 0,     250,   1'b0, 1'b0, '0},
    '{3012, 1,     -400,  1'b0, 1'b0, '0},
    '{4095, -1,    1250,  1'b0, 1'b0, '0},
    '{2999, -1,    1249,  1'b1, 1'b0, '0},
    '{3999, 1000,  449,   1'b0, 1'b0, '0}
  };

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one monitor step on the bench's own state
  function automatic result_t monitor_step(meas_t m);
    result_t r;
    battery_code_t mode_next;
    int pct;
    pct = 0;
    if (m.mv <= V_MIN_MV) pct = 0;
    else if (m.mv >= V_MAX_MV) pct = 100;
    else pct = (int'(m.mv) - int'(V_MIN_MV)) / 12;
    r.percent = pct[PCT_W-1:0];

    if (!m.chg) r.charge_code = CHG_NONE;
    else if (m.cur < CUR_FAST) r.charge_code = CHG_FAST;
    else if (m.cur < CUR_SLOW) r.charge_code = CHG_SLOW;
    else if (m.cur < CUR_TRICKLE) r.charge_code = CHG_TRICKLE;
    else if (pct >= 100) r.charge_code = CHG_COMPLETE;
    else r.charge_code = CHG_ERROR;

    r.charge_command = CMD_NONE;
    r.temp_event = TEV_NONE;
    if (int'(m.temp) > int'(lim_hot)) begin
      r.charge_command = CMD_DISABLE;
      if (!hot_flag) begin
        r.temp_event = TEV_HIGH;
        hot_flag = 1'b1;
      end
    end else if (int'(m.temp) < int'(lim_cool) && hot_flag) begin
      r.charge_command = CMD_ENABLE;
      r.temp_event = TEV_NORMAL;
      hot_flag = 1'b0;
    end

    // full is tested before high
    if (m.chg) mode_next = BAT_CHARGING;
    else if (pct <= int'(thr_crit)) mode_next = BAT_CRITICAL;
    else if (pct <= int'(thr_low)) mode_next = BAT_LOW;
    else if (pct >= int'(PCT_FULL)) mode_next = BAT_FULL;
    else if (pct > int'(PCT_HIGH)) mode_next = BAT_HIGH;
    else mode_next = BAT_NORMAL;
    r.battery_code = mode_next;

    r.state_event = SEV_NONE;
    if (mode_next != mode_now) begin
      case (mode_next)
        BAT_LOW:      r.state_event = SEV_LOW;
        BAT_CRITICAL: r.state_event = SEV_CRITICAL;
        BAT_CHARGING: r.state_event = SEV_CHARGING;
        default:      r.state_event = SEV_NORMAL;
      endcase
    end
    mode_now = mode_next;
    r.temp_warning = hot_flag;
    return r;
  endfunction

  // mostly values close to the decision points, some anywhere in the field
  function automatic meas_t random_meas();
    meas_t m;
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 12) v = $urandom_range(0, 8191);
    else if (r < 27) v = $urandom_range(0, 5000);
    else if (r < 50) begin
      case ($urandom_range(0, 4))
        0: v = int'(V_MIN_MV);
        1: v = int'(V_MAX_MV);
        2: v = int'(V_MIN_MV) + 12 * int'(thr_low);
        3: v = int'(V_MIN_MV) + 12 * int'(thr_crit);
        default: v = int'(V_MIN_MV) + 12 * int'(PCT_HIGH);
      endcase
      v = v + $urandom_range(0, 30) - 15;
    end else v = prev_mv + $urandom_range(0, 72) - 36;
    v = clamp_int(v, 0, 8191);
    if (v >= 2900 && v <= 4300) prev_mv = v;
    m.mv = v[VOLT_W-1:0];

    r = $urandom_range(0, 99);
    if (r < 25) v = $urandom_range(0, 4095) - 2048;
    else if (r < 70) begin
      case ($urandom_range(0, 2))
        0: v = int'(CUR_FAST);
        1: v = int'(CUR_SLOW);
        default: v = int'(CUR_TRICKLE);
      endcase
      v = v + $urandom_range(0, 6) - 3;
    end else v = $urandom_range(0, 600) - 550;
    m.cur = v[CUR_W-1:0];

    r = $urandom_range(0, 99);
    if (r < 15) v = $urandom_range(0, 4095) - 2048;
    else if (r < 35) v = $urandom_range(0, 1650) - 400;
    else if (r < 70) v = int'(lim_hot) + $urandom_range(0, 8) - 4;
    else v = int'(lim_cool) + $urandom_range(0, 8) - 4;
    v = clamp_int(v, -2048, 2047);
    m.temp = v[TEMP_W-1:0];

    if ($urandom_range(0, 9) == 0) chg_level = !chg_level;
    m.chg = chg_level;
    return m;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    if (n_errors <= 40)
      $display("%0t result %0d %s: got %0d want %0d", $time, n_results, what, got, want);
  endtask

  task automatic send_measurement(meas_t m, bit known, result_t want);
    result_t predicted;
    int gap;
    if (idle_level != 0 && $urandom_range(0, (idle_level == 2) ? 2 : 9) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_voltage_mv      <= m.mv;
    in_current_ma      <= m.cur;
    in_temp_decidegree <= m.temp;
    in_charge_enabled  <= m.chg;
    do @(posedge clk); while (!in_ready);
    predicted = monitor_step(m);
    pending_results.push_back(known ? want : predicted);
    n_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(logic [CFG_W-1:0] w_low, logic [CFG_W-1:0] w_crit,
                              logic [CFG_W-1:0] w_hot, logic [CFG_W-1:0] w_cool);
    logic [CFG_W-1:0] vals [4];
    vals = '{w_low, w_crit, w_hot, w_cool};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we   <= 1'b0;
    thr_low  = w_low[LOW_W-1:0];
    thr_crit = w_crit[CRIT_W-1:0];
    lim_hot  = w_hot[LIMIT_W-1:0];
    lim_cool = w_cool[LIMIT_W-1:0];
    n_settings++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_ready  <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (idle_level == 0) out_ready <= 1'b1;
      else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, (idle_level == 2) ? 3 : 9) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        head_result = pending_results.pop_front();
        if (out_percent !== head_result.percent)
          report_mismatch("percent", out_percent, head_result.percent);
        if (out_charge_code !== head_result.charge_code)
          report_mismatch("charge_code", out_charge_code, head_result.charge_code);
        if (out_battery_code !== head_result.battery_code)
          report_mismatch("battery_code", out_battery_code, head_result.battery_code);
        if (out_charge_command !== head_result.charge_command)
          report_mismatch("charge_command", out_charge_command, head_result.charge_command);
        if (out_temp_event !== head_result.temp_event)
          report_mismatch("temp_event", out_temp_event, head_result.temp_event);
        if (out_state_event !== head_result.state_event)
          report_mismatch("state_event", out_state_event, head_result.state_event);
        if (out_temp_warning !== head_result.temp_warning)
          report_mismatch("temp_warning", out_temp_warning, head_result.temp_warning);
        if (head_result.state_event != SEV_NONE) n_state_events++;
        if (head_result.temp_event != TEV_NONE) n_temp_events++;
        n_results++;
      end
    end
  end

  initial begin
    meas_t m;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_LOW;
    cfg_wdata          <= '0;
    in_valid           <= 1'b0;
    in_voltage_mv      <= '0;
    in_current_ma      <= '0;
    in_temp_decidegree <= '0;
    in_charge_enabled  <= 1'b0;
    thr_low            = LOW_RST;
    thr_crit           = CRIT_RST;
    lim_hot            = TCRIT_RST;
    lim_cool           = TREL_RST;
    mode_now           = BAT_NORMAL;
    hot_flag           = 1'b0;
    idle_level         = 1;
    n_errors           = 0;
    n_items            = 0;
    n_results          = 0;
    n_state_events     = 0;
    n_temp_events      = 0;
    n_settings         = 1;
    prev_mv            = 3600;
    chg_level          = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_PROBES; i++) begin
      m.mv   = probe_rows[i].mv[VOLT_W-1:0];
      m.cur  = probe_rows[i].cur[CUR_W-1:0];
      m.temp = probe_rows[i].temp[TEMP_W-1:0];
      m.chg  = probe_rows[i].chg;
      send_measurement(m, probe_rows[i].known, probe_rows[i].want);
    end

    for (int s = 1; s <= N_SETS; s++) begin
      wait_drained();
      case (s)
        1: begin
          write_config(11'd5, 11'd1, 11'd0, 11'd0);
          idle_level = 2;
        end
        2: begin
          write_config(11'd50, 11'd20, 11'd1250, 11'd1250);
          idle_level = 0;
        end
        3: begin
          // critical above low, release above the cut limit
          write_config(11'd5, 11'd20, 11'd300, 11'd600);
          idle_level = 1;
        end
        4: begin
          write_config(11'($urandom_range(5, 50)), 11'($urandom_range(1, 20)),
                       11'($urandom_range(0, 1250)), 11'($urandom_range(0, 1250)));
          idle_level = 2;
        end
        5: begin
          // full-width data, upper bits dropped by the threshold registers
          write_config(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                       11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
          idle_level = 1;
        end
        default: begin
          write_config(11'(LOW_RST), 11'(CRIT_RST), TCRIT_RST, TREL_RST);
          idle_level = 0;
        end
      endcase
      repeat (ITEMS_PER_SET) send_measurement(random_meas(), 1'b0, '0);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("summary: %0d items under %0d register settings, %0d results compared",
             n_items, n_settings, n_results);
    $display("summary: %0d battery mode events, %0d temperature events",
             n_state_events, n_temp_events);
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
